// ===== rtl/rcfp_pkg.sv =====
// Shared types, codes and character constants of the command frame parser.
package rcfp_pkg;

  localparam int MAX_ARGS_DEF     = 1024;
  localparam int MAX_BULK_LEN_DEF = 1048576;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_LIMIT = 2'd1;

  localparam logic [10:0] ARG_LIMIT_RST  = 11'd1024;
  localparam logic [20:0] BULK_LIMIT_RST = 21'd1048576;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_ARRAY_MARK,
    PH_COUNT_LINE,
    PH_COUNT_LF,
    PH_BULK_MARK,
    PH_BULK_LINE,
    PH_BULK_LF,
    PH_PAYLOAD,
    PH_TRAIL_CR,
    PH_TRAIL_LF
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_ARG_END,
    KIND_EMPTY,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_ARRAY_MARK,
    ERR_BULK_MARK,
    ERR_NUMBER,
    ERR_NEGATIVE,
    ERR_LIMIT,
    ERR_CRLF
  } err_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       resync;
  } in_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [9:0]  arg_index;
    logic [20:0] arg_length;
    logic [10:0] arg_total;
    logic        command_done;
    err_t        error_code;
  } out_res_t;

endpackage

// ===== rtl/rcfp_parser.sv =====
// Frame parse state, number line accumulator and result build for one byte.
module rcfp_parser
  import rcfp_pkg::*;
#(
  parameter int MAX_ARGS     = MAX_ARGS_DEF,
  parameter int MAX_BULK_LEN = MAX_BULK_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  in_req_t     req,
  input  logic [10:0] alim_cfg,
  input  logic [20:0] blim_cfg,
  output logic        res_vld,
  output out_res_t    res
);

  localparam logic [31:0] MAX_ARGS_U = 32'(MAX_ARGS);
  localparam logic [31:0] MAX_BULK_U = 32'(MAX_BULK_LEN);

  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        empty_r, empty_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        over_r, over_nxt;
  logic [10:0] decl_r, decl_nxt;
  logic [10:0] arg_r, arg_nxt;
  logic [20:0] left_r, left_nxt;
  logic [20:0] len_r, len_nxt;
  logic        hold_r, hold_nxt;

  logic [10:0] alim;
  logic [20:0] blim;
  logic [20:0] lim;
  logic [7:0]  b;
  logic        is_digit;
  logic        sign_char;
  logic [24:0] acc10;
  logic        line_bad;
  err_t        line_code;
  logic        err_v;
  err_t        err_c;
  logic        last_arg;
  logic        active;

  assign alim = ({21'b0, alim_cfg} < MAX_ARGS_U) ? alim_cfg : MAX_ARGS_U[10:0];
  assign blim = ({11'b0, blim_cfg} < MAX_BULK_U) ? blim_cfg : MAX_BULK_U[20:0];
  assign lim  = (phase_r == PH_COUNT_LINE) ? {10'b0, alim} : blim;

  assign b         = req.stream_byte;
  assign active    = go && !req.resync && !hold_r;
  assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign sign_char = empty_r && ((b == CH_MINUS) || (b == CH_PLUS));
  assign acc10     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {21'b0, b[3:0]};
  assign last_arg  = ({1'b0, arg_r} + 12'd1) >= {1'b0, decl_r};

  always_comb begin
    line_bad  = 1'b1;
    line_code = ERR_NUMBER;
    if (empty_r) begin
      line_code = ERR_NUMBER;
    end else if (neg_r && ((acc_r != 21'd0) || over_r)) begin
      line_code = ERR_NEGATIVE;
    end else if (over_r) begin
      line_code = ERR_LIMIT;
    end else begin
      line_bad = 1'b0;
    end
  end

  // Error decode per phase
  always_comb begin
    err_v = 1'b0;
    err_c = ERR_NUMBER;
    case (phase_r)
      PH_ARRAY_MARK: begin
        err_v = (b != CH_STAR);
        err_c = ERR_ARRAY_MARK;
      end
      PH_COUNT_LINE, PH_BULK_LINE: begin
        err_v = (b != CH_CR) && !sign_char && !is_digit;
        err_c = ERR_NUMBER;
      end
      PH_COUNT_LF, PH_BULK_LF: begin
        err_v = (b != CH_LF) || line_bad;
        err_c = (b != CH_LF) ? ERR_NUMBER : line_code;
      end
      PH_BULK_MARK: begin
        err_v = (b != CH_DOLLAR);
        err_c = ERR_BULK_MARK;
      end
      PH_TRAIL_CR: begin
        err_v = (b != CH_CR);
        err_c = ERR_CRLF;
      end
      PH_TRAIL_LF: begin
        err_v = (b != CH_LF);
        err_c = ERR_CRLF;
      end
      default: begin
        err_v = 1'b0;
        err_c = ERR_NUMBER;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    empty_nxt = empty_r;
    acc_nxt   = acc_r;
    over_nxt  = over_r;
    decl_nxt  = decl_r;
    arg_nxt   = arg_r;
    left_nxt  = left_r;
    len_nxt   = len_r;
    hold_nxt  = hold_r;
    if (go && req.resync) begin
      phase_nxt = PH_ARRAY_MARK;
      neg_nxt   = 1'b0;
      empty_nxt = 1'b1;
      acc_nxt   = '0;
      over_nxt  = 1'b0;
      decl_nxt  = '0;
      arg_nxt   = '0;
      left_nxt  = '0;
      len_nxt   = '0;
      hold_nxt  = 1'b0;
    end else if (active && err_v) begin
      hold_nxt = 1'b1;
    end else if (active) begin
      case (phase_r)
        PH_ARRAY_MARK, PH_BULK_MARK: begin
          neg_nxt   = 1'b0;
          empty_nxt = 1'b1;
          acc_nxt   = '0;
          over_nxt  = 1'b0;
          phase_nxt = (phase_r == PH_ARRAY_MARK) ? PH_COUNT_LINE : PH_BULK_LINE;
        end
        PH_COUNT_LINE, PH_BULK_LINE: begin
          if (b == CH_CR) begin
            phase_nxt = (phase_r == PH_COUNT_LINE) ? PH_COUNT_LF : PH_BULK_LF;
          end else if (sign_char) begin
            neg_nxt   = (b == CH_MINUS);
            empty_nxt = 1'b0;
          end else begin
            empty_nxt = 1'b0;
            if (!over_r) begin
              if (acc10 > {4'b0, lim}) begin
                over_nxt = 1'b1;
              end else begin
                acc_nxt = acc10[20:0];
              end
            end
          end
        end
        PH_COUNT_LF: begin
          if (acc_r == 21'd0) begin
            phase_nxt = PH_ARRAY_MARK;
            neg_nxt   = 1'b0;
            empty_nxt = 1'b1;
            acc_nxt   = '0;
            over_nxt  = 1'b0;
            decl_nxt  = '0;
            arg_nxt   = '0;
            left_nxt  = '0;
            len_nxt   = '0;
          end else begin
            decl_nxt  = acc_r[10:0];
            arg_nxt   = '0;
            phase_nxt = PH_BULK_MARK;
          end
        end
        PH_BULK_LF: begin
          len_nxt   = acc_r;
          left_nxt  = acc_r;
          phase_nxt = (acc_r == 21'd0) ? PH_TRAIL_CR : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (left_r != 21'd0) begin
            left_nxt = left_r - 21'd1;
          end
          if (left_r <= 21'd1) begin
            phase_nxt = PH_TRAIL_CR;
          end
        end
        PH_TRAIL_CR: begin
          phase_nxt = PH_TRAIL_LF;
        end
        PH_TRAIL_LF: begin
          if (last_arg) begin
            phase_nxt = PH_ARRAY_MARK;
            neg_nxt   = 1'b0;
            empty_nxt = 1'b1;
            acc_nxt   = '0;
            over_nxt  = 1'b0;
            decl_nxt  = '0;
            arg_nxt   = '0;
            left_nxt  = '0;
            len_nxt   = '0;
          end else begin
            arg_nxt   = arg_r + 11'd1;
            phase_nxt = PH_BULK_MARK;
          end
        end
        default: begin
          phase_nxt = PH_ARRAY_MARK;
          neg_nxt   = 1'b0;
          empty_nxt = 1'b1;
          acc_nxt   = '0;
          over_nxt  = 1'b0;
          decl_nxt  = '0;
          arg_nxt   = '0;
          left_nxt  = '0;
          len_nxt   = '0;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res_vld          = 1'b0;
    res              = '0;
    res.kind         = KIND_PAYLOAD;
    res.error_code   = ERR_ARRAY_MARK;
    if (active && err_v) begin
      res_vld        = 1'b1;
      res.kind       = KIND_ERROR;
      res.arg_index  = arg_r[9:0];
      res.arg_total  = decl_r;
      res.error_code = err_c;
    end else if (active) begin
      case (phase_r)
        PH_COUNT_LF: begin
          if (acc_r == 21'd0) begin
            res_vld          = 1'b1;
            res.kind         = KIND_EMPTY;
            res.command_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_vld       = 1'b1;
          res.kind      = KIND_PAYLOAD;
          res.payload   = b;
          res.arg_index = arg_r[9:0];
          res.arg_total = decl_r;
        end
        PH_TRAIL_LF: begin
          res_vld          = 1'b1;
          res.kind         = KIND_ARG_END;
          res.arg_index    = arg_r[9:0];
          res.arg_length   = len_r;
          res.arg_total    = decl_r;
          res.command_done = last_arg;
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ARRAY_MARK;
      neg_r   <= 1'b0;
      empty_r <= 1'b1;
      acc_r   <= '0;
      over_r  <= 1'b0;
      decl_r  <= '0;
      arg_r   <= '0;
      left_r  <= '0;
      len_r   <= '0;
      hold_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      empty_r <= empty_nxt;
      acc_r   <= acc_nxt;
      over_r  <= over_nxt;
      decl_r  <= decl_nxt;
      arg_r   <= arg_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      hold_r  <= hold_nxt;
    end
  end

  a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r && !req.resync) |-> !res_vld)
    else $error("result produced during error hold");

  a_err_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind == KIND_ERROR) |=> hold_r)
    else $error("error result without hold");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (left_r != 21'd0))
    else $error("payload phase with no bytes left");

  a_arg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BULK_MARK) |-> (arg_r < decl_r))
    else $error("argument index beyond declared count");

endmodule

// ===== rtl/rcfp_out_buf.sv =====
// Result register with stall hold toward the downstream side.
module rcfp_out_buf
  import rcfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  out_res_t load_data,
  output logic     free,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  logic     vld_r, vld_nxt;
  out_res_t data_r;

  assign free      = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt = vld_r && out_stall;
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ===== rtl/resp_command_frame_parser_top.sv =====
// Top level of the command frame parser: input register, limits, parser, result register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_data   (in_req_t)
//   out_    | output    | out_valid/out_stall | out_data  (out_res_t)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless out_stall holds a full result register.
// The per-byte phase update and times-ten accumulate sit between the input and result registers.
// Synchronous active-low reset; limits reset to 1024 and 1048576, no clearing pass.
// out_stall holds the result register; the input register keeps taking requests while it is free.
module resp_command_frame_parser_top
  import rcfp_pkg::*;
#(
  parameter int MAX_ARGS     = MAX_ARGS_DEF,
  parameter int MAX_BULK_LEN = MAX_BULK_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_res_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [20:0]          cfg_data
);

  logic        stg_vld_r, stg_vld_nxt;
  in_req_t     stg_req_r;
  logic [10:0] arg_limit_r;
  logic [20:0] bulk_limit_r;
  logic        free;
  logic        go;
  logic        accept;
  logic        res_vld;
  out_res_t    res;

  assign cfg_ready = 1'b1;
  assign go        = stg_vld_r && free;
  assign in_stall  = stg_vld_r && !free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    stg_vld_nxt = stg_vld_r && !go;
    if (accept) begin
      stg_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_limit_r  <= ARG_LIMIT_RST;
      bulk_limit_r <= BULK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ARG_LIMIT:  arg_limit_r  <= cfg_data[10:0];
        CFG_BULK_LIMIT: bulk_limit_r <= cfg_data;
        default: begin
          arg_limit_r <= arg_limit_r;
        end
      endcase
    end
  end

  rcfp_parser #(
    .MAX_ARGS     (MAX_ARGS),
    .MAX_BULK_LEN (MAX_BULK_LEN)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .req      (stg_req_r),
    .alim_cfg (arg_limit_r),
    .blim_cfg (bulk_limit_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  rcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .load_data (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
